// File: src/sftm_pkg.sv
package sftm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int STAT_W      = 3;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 144;

    typedef enum logic [STAT_W-1:0] {
        STAT_MERGED      = 3'd0,
        STAT_INSERTED    = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_READ_OK     = 3'd3,
        STAT_READ_BEYOND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD
    } state_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic add_en;
        logic ins_en;
    } cell_ctl_t;

endpackage

// File: src/sftm_mul.sv
module sftm_mul
(
    input  logic                             clk,
    input  logic [sftm_pkg::WORD_W-1:0]      a,
    input  logic [sftm_pkg::WORD_W-1:0]      b,
    output logic [sftm_pkg::WORD_W-1:0]      prod
);

    // low word of a * b, two register stages
    logic [sftm_pkg::WORD_W-1:0] pp_ll_reg;
    logic [sftm_pkg::HALF_W-1:0] pp_lh_reg;
    logic [sftm_pkg::HALF_W-1:0] pp_hl_reg;
    logic [sftm_pkg::WORD_W-1:0] prod_reg;

    logic [sftm_pkg::WORD_W-1:0] pp_ll_next;
    logic [sftm_pkg::WORD_W-1:0] pp_lh_full;
    logic [sftm_pkg::WORD_W-1:0] pp_hl_full;
    logic [sftm_pkg::HALF_W-1:0] cross_sum;
    logic [sftm_pkg::WORD_W-1:0] prod_next;

    always_comb
    begin
        pp_ll_next = a[sftm_pkg::HALF_W-1:0] * b[sftm_pkg::HALF_W-1:0];
        pp_lh_full = a[sftm_pkg::HALF_W-1:0] * b[sftm_pkg::WORD_W-1:sftm_pkg::HALF_W];
        pp_hl_full = a[sftm_pkg::WORD_W-1:sftm_pkg::HALF_W] * b[sftm_pkg::HALF_W-1:0];
        cross_sum  = pp_lh_reg + pp_hl_reg;
        prod_next  = pp_ll_reg + {cross_sum, {sftm_pkg::HALF_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_full[sftm_pkg::HALF_W-1:0];
        pp_hl_reg <= pp_hl_full[sftm_pkg::HALF_W-1:0];
        prod_reg  <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: src/sftm_cell.sv
module sftm_cell
(
    input  logic                         clk,
    input  sftm_pkg::cell_ctl_t          ctl,
    input  logic                         valid,
    input  logic [sftm_pkg::WORD_W-1:0]  key,
    input  logic [sftm_pkg::WORD_W-1:0]  prod,
    input  logic                         prev_lt,
    input  logic [sftm_pkg::WORD_W-1:0]  prev_base,
    input  logic [sftm_pkg::WORD_W-1:0]  prev_exp,
    output logic                         lt,
    output logic                         boundary,
    output logic                         hit,
    output logic [sftm_pkg::WORD_W-1:0]  base,
    output logic [sftm_pkg::WORD_W-1:0]  exp_val
);

    logic [sftm_pkg::WORD_W-1:0] base_reg, base_next;
    logic [sftm_pkg::WORD_W-1:0] exp_reg, exp_next;
    logic                        lt_reg, lt_next;
    logic                        eq_reg, eq_next;

    always_comb
    begin
        lt_next   = lt_reg;
        eq_next   = eq_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        if (ctl.cmp_en)
        begin
            lt_next = valid && (base_reg < key);
            eq_next = valid && (base_reg == key);
        end
        if (ctl.add_en && boundary && eq_reg)
        begin
            exp_next = exp_reg + prod;
        end
        if (ctl.ins_en)
        begin
            if (boundary)
            begin
                base_next = key;
                exp_next  = prod;
            end
            else if (!lt_reg)
            begin
                // above the insert point: take the neighbor's entry
                base_next = prev_base;
                exp_next  = prev_exp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        lt_reg   <= lt_next;
        eq_reg   <= eq_next;
    end

    assign lt       = lt_reg;
    assign boundary = prev_lt && !lt_reg;
    assign hit      = boundary && eq_reg;
    assign base     = base_reg;
    assign exp_val  = exp_reg;

endmodule

// File: src/sorted_factor_table_merge.sv
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tuser: req_type; tdata: base_in, exponent_in, read_index
// m_*       out  m_tvalid / m_tready       tuser: status; tdata: position, base_out,
//                                          exponent_out, entry_count
// cfg_*     in   cfg_valid / cfg_ready     cfg_data: power
//
// every beat goes from accept to result register in these steps: accept, compare plus
// partial products, product sum plus entry select, table update; the next beat is
// taken in the update cycle of the last one, and the pacing is set by the 64x64 product
// split into 32-bit partial products over two stages
// reset empties the table at once (count to zero) and sets power to 1
// a stalled result holds the block in the update cycle; the table is not touched
// until the result register is free
module sorted_factor_table_merge
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] base_in, [127:64] exponent_in, [133:128] read_index, rest zero
    input  logic [sftm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] position, [69:6] base_out, [133:70] exponent_out, [140:134] entry_count
    output logic [sftm_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] status
    output logic [sftm_pkg::STAT_W-1:0]       m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sftm_pkg::WORD_W-1:0]       cfg_data
);

    localparam int DEPTH = sftm_pkg::TABLE_DEPTH;

    // control state
    sftm_pkg::state_t               state_reg, state_next;
    logic [sftm_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [sftm_pkg::WORD_W-1:0]    power_reg, power_next;
    logic                           out_valid_reg, out_valid_next;

    // item registers, loaded on accept
    logic                           req_reg;
    logic [sftm_pkg::WORD_W-1:0]    key_reg;
    logic [sftm_pkg::WORD_W-1:0]    expo_reg;
    logic [sftm_pkg::POS_W-1:0]     ridx_reg;

    // entry select, registered in the sum cycle
    logic [sftm_pkg::WORD_W-1:0]    sel_base_reg, sel_base_next;
    logic [sftm_pkg::WORD_W-1:0]    sel_exp_reg, sel_exp_next;
    logic [sftm_pkg::IDX_W-1:0]     sel_pos_reg, sel_pos_next;
    logic                           found_reg, found_next;

    // result register
    logic [sftm_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [sftm_pkg::STAT_W-1:0]    out_user_reg, out_user_next;

    logic                           accept;
    logic                           fire;
    logic                           full;
    logic                           rd_ok;
    logic [sftm_pkg::WORD_W-1:0]    prod;
    sftm_pkg::cell_ctl_t            ctl;
    sftm_pkg::status_t              status;
    logic [sftm_pkg::POS_W-1:0]     res_pos;
    logic [sftm_pkg::WORD_W-1:0]    res_base;
    logic [sftm_pkg::WORD_W-1:0]    res_exp;

    logic [DEPTH-1:0]               valid_vec;
    logic [DEPTH-1:0]               lt_vec;
    logic [DEPTH-1:0]               bnd_vec;
    logic [DEPTH-1:0]               hit_vec;
    logic [DEPTH-1:0]               sel_vec;
    logic [sftm_pkg::WORD_W-1:0]    base_vec [DEPTH];
    logic [sftm_pkg::WORD_W-1:0]    exp_vec  [DEPTH];

    // product pipeline: exponent operand stable from accept to update; power follows any cfg write
    sftm_mul u_mul
    (
        .clk  (clk),
        .a    (power_reg),
        .b    (expo_reg),
        .prod (prod)
    );

    // occupancy thermometer from the count
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = (i < int'(count_reg));
        end
    end

    // cell row: cell i hands its entry up to cell i+1 on an insert
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            sftm_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (valid_vec[g]),
                .key       (key_reg),
                .prod      (prod),
                .prev_lt   (1'b1),
                .prev_base (key_reg),
                .prev_exp  (prod),
                .lt        (lt_vec[g]),
                .boundary  (bnd_vec[g]),
                .hit       (hit_vec[g]),
                .base      (base_vec[g]),
                .exp_val   (exp_vec[g])
            );
        end
        else
        begin : g_rest
            sftm_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (valid_vec[g]),
                .key       (key_reg),
                .prod      (prod),
                .prev_lt   (lt_vec[g-1]),
                .prev_base (base_vec[g-1]),
                .prev_exp  (exp_vec[g-1]),
                .lt        (lt_vec[g]),
                .boundary  (bnd_vec[g]),
                .hit       (hit_vec[g]),
                .base      (base_vec[g]),
                .exp_val   (exp_vec[g])
            );
        end
    end

    // entry select: read index for reads, insert/merge point for merges
    always_comb
    begin
        sel_base_next = '0;
        sel_exp_next  = '0;
        sel_pos_next  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_vec[i] = req_reg ? (int'(ridx_reg) == i) : bnd_vec[i];
            if (sel_vec[i])
            begin
                sel_base_next = sel_base_next | base_vec[i];
                sel_exp_next  = sel_exp_next | exp_vec[i];
                sel_pos_next  = sel_pos_next | sftm_pkg::IDX_W'(i);
            end
        end
        found_next = |hit_vec;
    end

    assign accept    = s_tvalid && s_tready;
    assign fire      = (state_reg == sftm_pkg::ST_UPD) && (!out_valid_reg || m_tready);
    assign full      = (count_reg == sftm_pkg::CNT_W'(DEPTH));
    assign rd_ok     = (int'(ridx_reg) < int'(count_reg)) && (int'(ridx_reg) < DEPTH);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sftm_pkg::ST_IDLE: if (s_tvalid) state_next = sftm_pkg::ST_MUL;
            sftm_pkg::ST_MUL:  state_next = sftm_pkg::ST_SUM;
            sftm_pkg::ST_SUM:  state_next = sftm_pkg::ST_UPD;
            sftm_pkg::ST_UPD:
            begin
                if (fire)
                begin
                    state_next = s_tvalid ? sftm_pkg::ST_MUL : sftm_pkg::ST_IDLE;
                end
            end
            default:           state_next = sftm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready   = 1'b0;
        ctl.cmp_en = 1'b0;
        ctl.add_en = 1'b0;
        ctl.ins_en = 1'b0;
        case (state_reg)
            sftm_pkg::ST_IDLE: s_tready = 1'b1;
            sftm_pkg::ST_MUL:  ctl.cmp_en = 1'b1;
            sftm_pkg::ST_SUM:  ;
            sftm_pkg::ST_UPD:
            begin
                s_tready   = fire;
                ctl.add_en = fire && !req_reg && found_reg;
                ctl.ins_en = fire && !req_reg && !found_reg && !full;
            end
            default:           ;
        endcase
    end

    // result fields
    always_comb
    begin
        res_pos  = '0;
        res_base = '0;
        res_exp  = '0;
        if (req_reg)
        begin
            res_pos = ridx_reg;
            if (rd_ok)
            begin
                status   = sftm_pkg::STAT_READ_OK;
                res_base = sel_base_reg;
                res_exp  = sel_exp_reg;
            end
            else
            begin
                status = sftm_pkg::STAT_READ_BEYOND;
            end
        end
        else if (found_reg)
        begin
            status   = sftm_pkg::STAT_MERGED;
            res_pos  = sftm_pkg::POS_W'(sel_pos_reg);
            res_base = sel_base_reg;
            res_exp  = sel_exp_reg + prod;
        end
        else if (full)
        begin
            status = sftm_pkg::STAT_FULL;
        end
        else
        begin
            status   = sftm_pkg::STAT_INSERTED;
            res_pos  = sftm_pkg::POS_W'(sel_pos_reg);
            res_base = key_reg;
            res_exp  = prod;
        end
    end

    always_comb
    begin
        count_next     = count_reg + sftm_pkg::CNT_W'(ctl.ins_en);
        power_next     = (cfg_valid && cfg_ready) ? cfg_data : power_reg;
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (fire)
        begin
            out_data_next = {3'b000, sftm_pkg::COUNT_W'(count_next), res_exp, res_base,
                             res_pos};
            out_user_next = status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sftm_pkg::ST_IDLE;
            count_reg     <= '0;
            power_reg     <= sftm_pkg::WORD_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            power_reg     <= power_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            key_reg  <= s_tdata[63:0];
            expo_reg <= s_tdata[127:64];
            ridx_reg <= s_tdata[133:128];
        end
        if (state_reg == sftm_pkg::ST_SUM)
        begin
            sel_base_reg <= sel_base_next;
            sel_exp_reg  <= sel_exp_next;
            sel_pos_reg  <= sel_pos_next;
            found_reg    <= found_next;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // table never holds more entries than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("entry count above table depth");

    // sorted table: at most one insert/merge point
    a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sftm_pkg::ST_SUM) |-> $onehot0(bnd_vec))
        else $error("more than one insert point");

    // a matching base sits at the insert point only once
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sftm_pkg::ST_SUM) |-> $onehot0(hit_vec))
        else $error("duplicate base in table");

    // an insert never happens on a full table
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_en |-> !full)
        else $error("insert into full table");

    // compare cycle only after an accepted beat
    a_mul_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sftm_pkg::ST_MUL) |-> $past(accept))
        else $error("compare cycle without accepted beat");

endmodule
